// ===== hw/rtl/vn2d_pkg.sv =====
// vn2d_pkg: shared constants for the 2d value-noise block
// no dependencies; used by vn2d_front, vn2d_back and value_noise_2d_top
package vn2d_pkg;

  // fixed field and fraction widths
  localparam int FRAC_BITS  = 16;
  localparam int SCALE_BITS = 8;
  localparam int OUT_BITS   = 24;
  localparam int SEED_BITS  = 64;

  typedef logic [63:0] word_t;

  // corner hash multipliers
  localparam word_t HASH_MUL_X = 64'h9e3779b97f4a7c15;
  localparam word_t HASH_MUL_Y = 64'hc2b2ae3d27d4eb4f;

  // splitmix64 finalizer constants
  localparam word_t FIN_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam word_t FIN_MUL_B = 64'h94d049bb133111eb;
  localparam int    FIN_SHR_A = 30;
  localparam int    FIN_SHR_B = 27;
  localparam int    FIN_SHR_C = 31;

  // smoothstep 3 - 2t in q0.16 is 196608 - 2f
  localparam logic [17:0] EASE_THREE = 18'd196608;
  localparam logic [16:0] Q16_ONE    = 17'd65536;

endpackage

// ===== hw/rtl/vn2d_front.sv =====
// vn2d_front: floor division of both coordinates by the cell scale, one bit per stage
// produces cell indices and q0.16 fractions; depends on vn2d_pkg
module vn2d_front #(
  parameter int CB = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [CB-1:0]                       in_coord_x,
  input  logic [CB-1:0]                       in_coord_y,
  input  logic [vn2d_pkg::SCALE_BITS-1:0]     in_cell_scale,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [CB-1:0]                       out_cell_x,
  output logic [CB-1:0]                       out_cell_y,
  output logic [vn2d_pkg::FRAC_BITS-1:0]      out_frac_x,
  output logic [vn2d_pkg::FRAC_BITS-1:0]      out_frac_y
);

  localparam int SB = vn2d_pkg::SCALE_BITS;
  localparam int FB = vn2d_pkg::FRAC_BITS;

  typedef struct packed {
    logic          neg;
    logic [SB-1:0] rem;
    logic [CB-1:0] dvd;
  } div_lane_t;

  typedef struct packed {
    logic [CB-1:0] cidx;
    logic [SB-1:0] rem;
    logic [FB-1:0] frac;
  } frac_lane_t;

  // negative values divide their complement, which keeps floor semantics
  function automatic div_lane_t div_load(logic [CB-1:0] v);
    div_lane_t o;
    o.neg = v[CB-1];
    o.rem = '0;
    o.dvd = v[CB-1] ? ~v : v;
    return o;
  endfunction

  // one restoring division step on the coordinate
  function automatic div_lane_t div_step(div_lane_t c, logic [SB-1:0] s);
    div_lane_t   o;
    logic [SB:0] t;
    logic        q;
    t = {c.rem, c.dvd[CB-1]};
    q = (t >= {1'b0, s});
    if (q) begin
      t = t - {1'b0, s};
    end
    o.neg = c.neg;
    o.rem = t[SB-1:0];
    o.dvd = {c.dvd[CB-2:0], q};
    return o;
  endfunction

  // undo the complement: cell is ~q, remainder is s-1-r
  function automatic frac_lane_t fix_up(div_lane_t c, logic [SB-1:0] s);
    frac_lane_t o;
    o.cidx = c.neg ? ~c.dvd : c.dvd;
    o.rem  = c.neg ? (s - SB'(1) - c.rem) : c.rem;
    o.frac = '0;
    return o;
  endfunction

  // one step of remainder*2^16/scale
  function automatic frac_lane_t frac_step(frac_lane_t c, logic [SB-1:0] s);
    frac_lane_t  o;
    logic [SB:0] t;
    logic        q;
    t = {c.rem, 1'b0};
    q = (t >= {1'b0, s});
    if (q) begin
      t = t - {1'b0, s};
    end
    o.cidx = c.cidx;
    o.rem  = t[SB-1:0];
    o.frac = {c.frac[FB-2:0], q};
    return o;
  endfunction

  div_lane_t     div_x_r   [CB+1];
  div_lane_t     div_y_r   [CB+1];
  logic [SB-1:0] div_s_r   [CB+1];
  frac_lane_t    frac_x_r  [FB+1];
  frac_lane_t    frac_y_r  [FB+1];
  logic [SB-1:0] frac_s_r  [FB+1];
  logic [CB:0]   div_v_r;
  logic [FB:0]   frac_v_r;
  logic          en;

  // whole pipeline moves unless the last stage holds a transaction nobody takes
  assign en        = !frac_v_r[FB] || out_ready;
  assign in_ready  = en;
  assign out_valid = frac_v_r[FB];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r  <= '0;
      frac_v_r <= '0;
    end else if (en) begin
      div_v_r  <= {div_v_r[CB-1:0], in_valid};
      frac_v_r <= {frac_v_r[FB-1:0], div_v_r[CB]};
    end
  end

  // division stages
  always_ff @(posedge clk) begin
    if (en) begin
      div_x_r[0] <= div_load(in_coord_x);
      div_y_r[0] <= div_load(in_coord_y);
      div_s_r[0] <= (in_cell_scale == '0) ? SB'(1) : in_cell_scale;
      for (int k = 0; k < CB; k++) begin
        div_x_r[k+1] <= div_step(div_x_r[k], div_s_r[k]);
        div_y_r[k+1] <= div_step(div_y_r[k], div_s_r[k]);
        div_s_r[k+1] <= div_s_r[k];
      end
      frac_x_r[0] <= fix_up(div_x_r[CB], div_s_r[CB]);
      frac_y_r[0] <= fix_up(div_y_r[CB], div_s_r[CB]);
      frac_s_r[0] <= div_s_r[CB];
      for (int k = 0; k < FB; k++) begin
        frac_x_r[k+1] <= frac_step(frac_x_r[k], frac_s_r[k]);
        frac_y_r[k+1] <= frac_step(frac_y_r[k], frac_s_r[k]);
        frac_s_r[k+1] <= frac_s_r[k];
      end
    end
  end

  assign out_cell_x = frac_x_r[FB].cidx;
  assign out_cell_y = frac_y_r[FB].cidx;
  assign out_frac_x = frac_x_r[FB].frac;
  assign out_frac_y = frac_y_r[FB].frac;

endmodule

// ===== hw/rtl/vn2d_fifo.sv =====
// vn2d_fifo: small register queue between the front and back pipelines
// no dependencies; depth must be a power of two
module vn2d_fifo #(
  parameter int W     = 96,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != (AW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("fifo count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (AW+1)'(1)))
    else $error("fifo count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - (AW+1)'(1)))
    else $error("fifo count missed a pop");
`endif

endmodule

// ===== hw/rtl/vn2d_back.sv =====
// vn2d_back: smoothstep, four splitmix64 corner hashes and bilinear blend
// eleven-stage pipeline; depends on vn2d_pkg
module vn2d_back #(
  parameter int CB  = 32,
  parameter int VFB = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [CB-1:0]                       in_cell_x,
  input  logic [CB-1:0]                       in_cell_y,
  input  logic [vn2d_pkg::FRAC_BITS-1:0]      in_frac_x,
  input  logic [vn2d_pkg::FRAC_BITS-1:0]      in_frac_y,
  input  logic [vn2d_pkg::SEED_BITS-1:0]      seed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vn2d_pkg::OUT_BITS-1:0]       out_noise_value
);

  localparam int FB = vn2d_pkg::FRAC_BITS;
  localparam int PW = VFB + 17;
  localparam int NS = 11;

  logic [NS-1:0] v_r;
  logic          en;

  // stage 1: partial products of the cell hash terms, squares of the fractions
  logic [63:0]   pxll_r, pyll_r;
  logic [31:0]   pxm1_r, pxm2_r, pym1_r, pym2_r;
  logic [31:0]   sqx_r, sqy_r;
  logic [FB-1:0] fx1_r, fy1_r;
  // stage 2
  vn2d_pkg::word_t px_r, py_r;
  // stage 3..7: four corner lanes (tl, tr, bl, br)
  vn2d_pkg::word_t v3_r [4];
  logic [63:0]     ll4_r [4];
  logic [31:0]     m14_r [4], m24_r [4];
  vn2d_pkg::word_t v5_r [4];
  logic [63:0]     ll6_r [4];
  logic [31:0]     m16_r [4], m26_r [4];
  logic [VFB-1:0]  crn_r [4];
  // stage 8..11: blends
  logic [PW-1:0]   pa_r [4];
  logic [VFB-1:0]  top_r, bot_r;
  logic [PW-1:0]   qa_r, qb_r;
  logic [VFB-1:0]  val_r;
  // eased fractions ride along
  logic [FB-1:0]   sx_d_r [6];
  logic [FB-1:0]   sy_d_r [8];

  logic signed [CB-1:0] cxs, cys;
  vn2d_pkg::word_t      cx64, cy64;
  vn2d_pkg::word_t      vin [4];
  vn2d_pkg::word_t      v6c [4];
  vn2d_pkg::word_t      hsh [4];
  logic [49:0]          ekx, eky;
  logic [16:0]          wx, wy;
  logic [PW:0]          sum_t, sum_b, sum_v;
  logic [63:0]          val64;

  assign en        = !v_r[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[NS-1];

  always_comb begin
    cxs  = in_cell_x;
    cys  = in_cell_y;
    cx64 = 64'(cxs);
    cy64 = 64'(cys);
    // corner hash inputs; cell+1 times the multiplier is the product plus the multiplier
    vin[0] = px_r ^ py_r ^ seed;
    vin[1] = (px_r + vn2d_pkg::HASH_MUL_X) ^ py_r ^ seed;
    vin[2] = px_r ^ (py_r + vn2d_pkg::HASH_MUL_Y) ^ seed;
    vin[3] = (px_r + vn2d_pkg::HASH_MUL_X) ^ (py_r + vn2d_pkg::HASH_MUL_Y) ^ seed;
    for (int i = 0; i < 4; i++) begin
      v6c[i] = ll4_r[i] + {m14_r[i] + m24_r[i], 32'h0};
      v6c[i] = v6c[i] ^ (v6c[i] >> vn2d_pkg::FIN_SHR_B);
      hsh[i] = ll6_r[i] + {m16_r[i] + m26_r[i], 32'h0};
      hsh[i] = hsh[i] ^ (hsh[i] >> vn2d_pkg::FIN_SHR_C);
    end
    ekx   = 50'(sqx_r) * 50'(vn2d_pkg::EASE_THREE - {1'b0, fx1_r, 1'b0});
    eky   = 50'(sqy_r) * 50'(vn2d_pkg::EASE_THREE - {1'b0, fy1_r, 1'b0});
    wx    = vn2d_pkg::Q16_ONE - {1'b0, sx_d_r[5]};
    wy    = vn2d_pkg::Q16_ONE - {1'b0, sy_d_r[7]};
    sum_t = {1'b0, pa_r[0]} + {1'b0, pa_r[1]};
    sum_b = {1'b0, pa_r[2]} + {1'b0, pa_r[3]};
    sum_v = {1'b0, qa_r} + {1'b0, qb_r};
    val64 = 64'(val_r);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      pxll_r <= 64'(cx64[31:0]) * 64'(vn2d_pkg::HASH_MUL_X[31:0]);
      pxm1_r <= cx64[63:32] * vn2d_pkg::HASH_MUL_X[31:0];
      pxm2_r <= cx64[31:0] * vn2d_pkg::HASH_MUL_X[63:32];
      pyll_r <= 64'(cy64[31:0]) * 64'(vn2d_pkg::HASH_MUL_Y[31:0]);
      pym1_r <= cy64[63:32] * vn2d_pkg::HASH_MUL_Y[31:0];
      pym2_r <= cy64[31:0] * vn2d_pkg::HASH_MUL_Y[63:32];
      sqx_r  <= 32'(in_frac_x) * 32'(in_frac_x);
      sqy_r  <= 32'(in_frac_y) * 32'(in_frac_y);
      fx1_r  <= in_frac_x;
      fy1_r  <= in_frac_y;
      // stage 2: finish products, ease
      px_r      <= pxll_r + {pxm1_r + pxm2_r, 32'h0};
      py_r      <= pyll_r + {pym1_r + pym2_r, 32'h0};
      sx_d_r[0] <= ekx[47:32];
      sy_d_r[0] <= eky[47:32];
      for (int i = 1; i < 6; i++) begin
        sx_d_r[i] <= sx_d_r[i-1];
      end
      for (int i = 1; i < 8; i++) begin
        sy_d_r[i] <= sy_d_r[i-1];
      end
      for (int i = 0; i < 4; i++) begin
        // stage 3: first xor-shift
        v3_r[i]  <= vin[i] ^ (vin[i] >> vn2d_pkg::FIN_SHR_A);
        // stage 4: partials of the first finalizer multiply
        ll4_r[i] <= 64'(v3_r[i][31:0]) * 64'(vn2d_pkg::FIN_MUL_A[31:0]);
        m14_r[i] <= v3_r[i][63:32] * vn2d_pkg::FIN_MUL_A[31:0];
        m24_r[i] <= v3_r[i][31:0] * vn2d_pkg::FIN_MUL_A[63:32];
        // stage 5: sum and second xor-shift
        v5_r[i]  <= v6c[i];
        // stage 6: partials of the second finalizer multiply
        ll6_r[i] <= 64'(v5_r[i][31:0]) * 64'(vn2d_pkg::FIN_MUL_B[31:0]);
        m16_r[i] <= v5_r[i][63:32] * vn2d_pkg::FIN_MUL_B[31:0];
        m26_r[i] <= v5_r[i][31:0] * vn2d_pkg::FIN_MUL_B[63:32];
        // stage 7: final xor-shift, keep top bits
        crn_r[i] <= hsh[i][63 -: VFB];
      end
      // stage 8: x blend products
      pa_r[0] <= PW'(crn_r[0]) * PW'(wx);
      pa_r[1] <= PW'(crn_r[1]) * PW'(sx_d_r[5]);
      pa_r[2] <= PW'(crn_r[2]) * PW'(wx);
      pa_r[3] <= PW'(crn_r[3]) * PW'(sx_d_r[5]);
      // stage 9: x blend results
      top_r <= sum_t[VFB+15:16];
      bot_r <= sum_b[VFB+15:16];
      // stage 10: y blend products
      qa_r <= PW'(top_r) * PW'(wy);
      qb_r <= PW'(bot_r) * PW'(sy_d_r[7]);
      // stage 11: output register
      val_r <= sum_v[VFB+15:16];
    end
  end

  assign out_noise_value = val64[vn2d_pkg::OUT_BITS-1:0];

endmodule

// ===== hw/rtl/value_noise_2d_top.sv =====
// value_noise_2d_top: 2d value-noise sampler, front divider, queue and hash/blend back end
// depends on vn2d_pkg, vn2d_front, vn2d_fifo, vn2d_back

// One sample per clock cycle in steady state while out_ready stays high: the front divides
// both coordinates by the cell scale one bit per stage (COORD_BITS + 18 stages, cell
// index then the 16-bit fraction), a four-entry queue follows, and the back end hashes
// the four corners with two splitmix64 multiplies split into 32-bit partial products and
// blends them (11 stages). The queue lets the front keep taking items while a result
// waits on out_ready, until its four entries are full. A scale of zero counts as one.
// The seed is written through cfg_we/cfg_wdata and must only change while no samples
// are in flight.
module value_noise_2d_top #(
  parameter int COORD_BITS      = 32,
  parameter int VALUE_FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             in_coord_x,
  input  logic [COORD_BITS-1:0]             in_coord_y,
  input  logic [vn2d_pkg::SCALE_BITS-1:0]   in_cell_scale,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vn2d_pkg::OUT_BITS-1:0]     out_noise_value,
  input  logic                              cfg_we,
  input  logic [vn2d_pkg::SEED_BITS-1:0]    cfg_wdata
);

  localparam int FB = vn2d_pkg::FRAC_BITS;
  localparam int QW = 2 * COORD_BITS + 2 * FB;

  logic [vn2d_pkg::SEED_BITS-1:0] seed_r;
  logic                  f_valid, f_ready;
  logic [COORD_BITS-1:0] f_cell_x, f_cell_y;
  logic [FB-1:0]         f_frac_x, f_frac_y;
  logic                  q_valid, q_ready;
  logic [QW-1:0]         q_data;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // front: floor division and fractions
  vn2d_front #(.CB(COORD_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_cell_scale (in_cell_scale),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_cell_x    (f_cell_x),
    .out_cell_y    (f_cell_y),
    .out_frac_x    (f_frac_x),
    .out_frac_y    (f_frac_y)
  );

  // queue between front and back
  vn2d_fifo #(.W(QW), .DEPTH(4)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_cell_x, f_cell_y, f_frac_x, f_frac_y}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back: hashing and blending
  vn2d_back #(.CB(COORD_BITS), .VFB(VALUE_FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (q_valid),
    .in_ready        (q_ready),
    .in_cell_x       (q_data[QW-1 -: COORD_BITS]),
    .in_cell_y       (q_data[2*FB +: COORD_BITS]),
    .in_frac_x       (q_data[FB +: FB]),
    .in_frac_y       (q_data[0 +: FB]),
    .seed            (seed_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_noise_value (out_noise_value)
  );

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for value_noise_2d_top with a small sample scoreboard
// depends on vn2d_pkg and value_noise_2d_top

class noise_scoreboard;
  bit [63:0] seed_reg;
  logic [23:0] pending_q[$];
  int errors;

  // corner hash from a cell pair and the current seed, top 24 bits kept
  function bit [63:0] corner_hash(bit [63:0] ux, bit [63:0] uy);
    bit [63:0] v;
    v = (ux * vn2d_pkg::HASH_MUL_X) ^ (uy * vn2d_pkg::HASH_MUL_Y) ^ seed_reg;
    v = v ^ (v >> vn2d_pkg::FIN_SHR_A);
    v = v * vn2d_pkg::FIN_MUL_A;
    v = v ^ (v >> vn2d_pkg::FIN_SHR_B);
    v = v * vn2d_pkg::FIN_MUL_B;
    v = v ^ (v >> vn2d_pkg::FIN_SHR_C);
    return v >> 40;
  endfunction

  function bit [63:0] smooth(bit [63:0] f);
    bit [127:0] p;
    p = 128'(f) * f * (128'd196608 - 2 * f);
    return 64'(p >> 32);
  endfunction

  function bit [63:0] mix(bit [63:0] a, bit [63:0] b, bit [63:0] t);
    bit [127:0] p;
    p = 128'(a) * (65536 - t) + 128'(b) * t;
    return 64'(p >> 16);
  endfunction

  // floor division of a sign-extended coordinate by the scale
  function void split(logic [31:0] c, longint s, output bit [63:0] cidx,
                      output bit [63:0] rem);
    longint v, q, r;
    v = longint'(signed'(c));
    q = v / s;
    r = v % s;
    if (r < 0) begin
      r += s;
      q -= 1;
    end
    cidx = q;
    rem = r;
  endfunction

  // note an accepted input transaction
  function void note_sample(logic [31:0] x, logic [31:0] y, logic [7:0] sc);
    longint s;
    bit [63:0] cx, cy, rx, ry, fx, fy, tl, tr, bl, br;
    s = (sc == 0) ? 1 : sc;
    split(x, s, cx, rx);
    split(y, s, cy, ry);
    fx = smooth((rx << 16) / s);
    fy = smooth((ry << 16) / s);
    tl = corner_hash(cx, cy);
    tr = corner_hash(cx + 1, cy);
    bl = corner_hash(cx, cy + 1);
    br = corner_hash(cx + 1, cy + 1);
    pending_q.push_back(24'(mix(mix(tl, tr, fx), mix(bl, br, fx), fy)));
  endfunction

  // compare a result transaction with the oldest expectation
  function void check_result(logic [23:0] got);
    logic [23:0] want;
    if (pending_q.size() == 0) begin
      $error("noise_value: unexpected result %h", got);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      $error("noise_value: expected %h actual %h", want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic [31:0] in_coord_x = 0, in_coord_y = 0;
  logic [7:0] in_cell_scale = 1;
  logic [63:0] cfg_wdata = 0;
  logic in_ready, out_valid;
  logic [23:0] out_noise_value;
  noise_scoreboard sb = new();
  int hold_cycles = 0;
  int sink_wait = 0;
  int sink_draw;
  int out_cnt = 0;
  int seen_cnt = 0;
  bit hold_go = 0;
  bit hold_taken = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  value_noise_2d_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_cell_scale(in_cell_scale),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // one input transaction, after an optional idle gap; valid stays up between back-to-back ones
  task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [7:0] sc, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_cell_scale <= sc;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, y, sc);
    @(negedge clk);
  endtask

  // seed write once the pipe has drained
  task automatic write_seed(logic [63:0] v);
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.seed_reg = v;
  endtask

  function automatic logic [31:0] rand_coord();
    unique case ($urandom_range(0, 3))
      0: return $urandom_range(0, 600) - 300;
      1: return 32'h8000_0000 + $urandom_range(0, 600);
      2: return 32'h7fff_ffff - $urandom_range(0, 600);
      default: return $urandom;
    endcase
  endfunction

  // result sink: a random wait before each transaction plus one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1;
      hold_cycles <= 200;
      out_ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else if (seen_cnt != out_cnt) begin
      seen_cnt <= out_cnt;
      sink_draw = $urandom_range(0, 8);
      if (sink_draw == 0) begin
        out_ready <= 1;
      end else begin
        out_ready <= 0;
        sink_wait <= sink_draw - 1;
      end
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_noise_value);
      out_cnt++;
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [63:0] seeds[4];
    logic [31:0] edge_c[6];
    int i;
    seeds = '{64'h0123_4567_89ab_cdef, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h5555_aaaa_0f0f_f0f0};
    edge_c = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ff00};
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed extremes: reset seed, zero scale, scale one and 255, wrap corners
    for (i = 0; i < 6; i++) send_sample(edge_c[i], edge_c[5 - i], 8'd0, 0);
    for (i = 0; i < 6; i++) send_sample(edge_c[i], edge_c[i], 8'd255, 1);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 8'd1, 0);
    send_sample(32'hffff_ffff, 32'h7fff_fffe, 8'd254, 0);
    send_sample(32'd127, 32'hffff_ff81, 8'd128, 0);

    // long receiver hold-off while the sender keeps offering
    hold_go = 1;
    for (i = 0; i < 120; i++) send_sample(rand_coord(), rand_coord(), 8'($urandom), 0);

    for (int ph = 0; ph < 4; ph++) begin
      write_seed(seeds[ph]);
      for (i = 0; i < 380; i++)
        send_sample(rand_coord(), rand_coord(), 8'($urandom),
                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    end

    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
